@@ sv/pmvu_pkg.sv @@
package pmvu_pkg;

  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS  = 24;
  localparam int DATA_W     = 64;
  localparam int VAR_W      = DATA_W - 1;

  // multiplier: one 8-bit digit of the second operand per cycle
  localparam int MUL_DIGIT  = 8;
  localparam int MUL_STEPS  = DATA_W / MUL_DIGIT;
  localparam int PROD_W     = 2 * DATA_W;

  // square root of v * 2^FRAC_BITS, radicand padded to an even width
  localparam int RAD_W      = ((VAR_W + FRAC_BITS + 1) / 2) * 2;
  localparam int ROOT_W     = RAD_W / 2;

  localparam int STEP_W     = $clog2(DATA_W);
  localparam int NUM_T      = 5;
  localparam int T_W        = $clog2(NUM_T);
  localparam int NUM_SRC    = 32;

  localparam int PROG_LEN   = 30;
  localparam int PC_W       = $clog2(PROG_LEN);
  localparam int PC_MEAN    = 7;
  localparam int PC_LAST    = PROG_LEN - 1;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_MULF,
    OP_DIV
  } op_e;

  typedef enum logic [4:0] {
    SRC_N,
    SRC_S,
    SRC_U,
    SRC_V,
    SRC_PM,
    SRC_SM,
    SRC_UM,
    SRC_VM,
    SRC_PN,
    SRC_SN,
    SRC_UN,
    SRC_VN,
    SRC_NP,
    SRC_NP1,
    SRC_LPM,
    SRC_LPN,
    SRC_LN,
    SRC_N2,
    SRC_NDIFF,
    SRC_UP,
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_T3,
    SRC_T4
  } src_e;

  typedef enum logic [2:0] {
    DST_T0,
    DST_T1,
    DST_T2,
    DST_T3,
    DST_T4,
    DST_SP,
    DST_UP,
    DST_VP
  } dst_e;

  typedef struct packed {
    op_e  op;
    src_e sa;
    src_e sb;
    dst_e dst;
  } micro_t;

  typedef struct packed {
    logic   check;
    logic   start;
    micro_t uop;
    logic   commit;
    logic   root;
    logic   publish;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic err;
    logic np_one;
  } dp_status_t;

endpackage

@@ sv/pmvu_ctrl.sv @@
module pmvu_ctrl import pmvu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_accept_i,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       in_stall_o,
  output logic       out_valid_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ISSUE,
    S_WAIT,
    S_COMMIT,
    S_ROOT,
    S_ROOT_WAIT,
    S_OUT
  } state_e;

  state_e          state_q;
  logic [PC_W-1:0] pc_q;
  logic            out_valid_q;
  logic            publish;

  function automatic micro_t prog(input logic [PC_W-1:0] pc);
    micro_t m;
    m = '{OP_ADD, SRC_T0, SRC_T0, DST_T0};
    case (pc)
      PC_W'(0):  m = '{OP_SUB,  SRC_S,  SRC_SM,    DST_T0};
      PC_W'(1):  m = '{OP_ADD,  SRC_T0, SRC_SN,    DST_SP};
      PC_W'(2):  m = '{OP_MUL,  SRC_U,  SRC_N,     DST_T1};
      PC_W'(3):  m = '{OP_MUL,  SRC_UN, SRC_PN,    DST_T0};
      PC_W'(4):  m = '{OP_ADD,  SRC_T1, SRC_T0,    DST_T1};
      PC_W'(5):  m = '{OP_MUL,  SRC_UM, SRC_PM,    DST_T2};
      PC_W'(6):  m = '{OP_SUB,  SRC_T1, SRC_T2,    DST_T1};
      PC_W'(7):  m = '{OP_DIV,  SRC_T1, SRC_NP,    DST_UP};
      PC_W'(8):  m = '{OP_SUB,  SRC_UM, SRC_U,     DST_T0};
      PC_W'(9):  m = '{OP_MULF, SRC_T0, SRC_T0,    DST_T0};
      PC_W'(10): m = '{OP_MUL,  SRC_T0, SRC_PM,    DST_T0};
      PC_W'(11): m = '{OP_MUL,  SRC_VM, SRC_LPM,   DST_T1};
      PC_W'(12): m = '{OP_ADD,  SRC_T1, SRC_T0,    DST_T3};
      PC_W'(13): m = '{OP_SUB,  SRC_UN, SRC_UP,    DST_T0};
      PC_W'(14): m = '{OP_MULF, SRC_T0, SRC_T0,    DST_T0};
      PC_W'(15): m = '{OP_MUL,  SRC_T0, SRC_PN,    DST_T0};
      PC_W'(16): m = '{OP_MUL,  SRC_VN, SRC_LPN,   DST_T1};
      PC_W'(17): m = '{OP_ADD,  SRC_T1, SRC_T0,    DST_T4};
      PC_W'(18): m = '{OP_MUL,  SRC_U,  SRC_N2,    DST_T0};
      PC_W'(19): m = '{OP_SUB,  SRC_T0, SRC_T2,    DST_T0};
      PC_W'(20): m = '{OP_ADD,  SRC_U,  SRC_UP,    DST_T1};
      PC_W'(21): m = '{OP_MUL,  SRC_T1, SRC_NDIFF, DST_T1};
      PC_W'(22): m = '{OP_SUB,  SRC_T0, SRC_T1,    DST_T0};
      PC_W'(23): m = '{OP_SUB,  SRC_U,  SRC_UP,    DST_T1};
      PC_W'(24): m = '{OP_MULF, SRC_T1, SRC_T0,    DST_T0};
      PC_W'(25): m = '{OP_MUL,  SRC_V,  SRC_LN,    DST_T1};
      PC_W'(26): m = '{OP_ADD,  SRC_T1, SRC_T4,    DST_T1};
      PC_W'(27): m = '{OP_SUB,  SRC_T1, SRC_T3,    DST_T1};
      PC_W'(28): m = '{OP_ADD,  SRC_T1, SRC_T0,    DST_T1};
      PC_W'(29): m = '{OP_DIV,  SRC_T1, SRC_NP1,   DST_VP};
      default:   m = '{OP_ADD,  SRC_T0, SRC_T0,    DST_T0};
    endcase
    return m;
  endfunction

  assign publish = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    cmd_o.check   = (state_q == S_CHECK);
    cmd_o.start   = (state_q == S_ISSUE);
    cmd_o.uop     = prog(pc_q);
    cmd_o.commit  = (state_q == S_COMMIT);
    cmd_o.root    = (state_q == S_ROOT);
    cmd_o.publish = publish;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (publish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept_i) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          pc_q <= '0;
          // empty total: skip the update, report the held state
          state_q <= status_i.err ? S_ROOT : S_ISSUE;
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (status_i.done) begin
            if (pc_q == PC_W'(PC_LAST) || (pc_q == PC_W'(PC_MEAN) && status_i.np_one)) begin
              state_q <= S_COMMIT;
            end else begin
              pc_q    <= pc_q + PC_W'(1);
              state_q <= S_ISSUE;
            end
          end
        end
        S_COMMIT: state_q <= S_ROOT;
        S_ROOT:   state_q <= S_ROOT_WAIT;
        S_ROOT_WAIT: begin
          if (status_i.done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (publish) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.check, cmd_o.start, cmd_o.commit, cmd_o.root, cmd_o.publish}))
    else $error("more than one datapath command at once");

  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.done |-> (state_q == S_WAIT || state_q == S_ROOT_WAIT))
    else $error("unit done while controller not waiting");

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while still held");

endmodule

@@ sv/pmvu_dp.sv @@
module pmvu_dp import pmvu_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_load_i,
  input  logic [COUNT_BITS-1:0]        old_count_i,
  input  logic signed [DATA_W-1:0]     old_sum_i,
  input  logic signed [DATA_W-1:0]     old_mean_i,
  input  logic [VAR_W-1:0]             old_variance_i,
  input  logic [COUNT_BITS-1:0]        new_count_i,
  input  logic signed [DATA_W-1:0]     new_sum_i,
  input  logic signed [DATA_W-1:0]     new_mean_i,
  input  logic [VAR_W-1:0]             new_variance_i,
  input  dp_cmd_t                      cmd_i,
  output dp_status_t                   status_o,
  output logic [COUNT_BITS-1:0]        total_count_o,
  output logic signed [DATA_W-1:0]     total_sum_o,
  output logic signed [DATA_W-1:0]     total_mean_o,
  output logic [VAR_W-1:0]             total_variance_o,
  output logic [VAR_W-1:0]             total_std_dev_o,
  output logic                         empty_error_o
);

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_MFIN,
    U_DIV,
    U_SQRT
  } unit_e;

  localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // running state
  logic [COUNT_BITS-1:0] n_q;
  logic [DATA_W-1:0]     s_q, u_q, v_q;

  // accepted item
  logic [COUNT_BITS-1:0] pm_q, pn_q;
  logic [DATA_W-1:0]     sm_q, um_q, sn_q, un_q;
  logic [VAR_W-1:0]      vm_q, vn_q;

  logic [DATA_W-1:0]     t_q [NUM_T];
  logic [DATA_W-1:0]     sp_q, up_q, vp_q;
  logic                  err_q;

  unit_e                 unit_q;
  logic [STEP_W-1:0]     step_q;
  logic                  done_q;

  logic [DATA_W-1:0]     mag_a_q, mag_b_q;
  logic [PROD_W-1:0]     acc_q;
  logic                  neg_q, shf_q;
  logic [DATA_W-1:0]     dvd_q;
  logic [COUNT_BITS-1:0] dsr_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic [RAD_W-1:0]      rad_q;
  logic [ROOT_W+2:0]     srem_q;
  logic [ROOT_W-1:0]     root_q;

  logic [COUNT_BITS-1:0] out_cnt_q;
  logic [DATA_W-1:0]     out_sum_q, out_mean_q;
  logic [VAR_W-1:0]      out_var_q, out_std_q;
  logic                  out_err_q;

  // count terms
  logic signed [COUNT_BITS+1:0] np_raw;
  logic signed [COUNT_BITS:0]   ndiff;
  logic [COUNT_BITS-1:0]        np_c, np1, lpm, lpn, ln;
  logic                         err_c;

  assign np_raw = $signed({2'b00, n_q}) - $signed({2'b00, pm_q}) + $signed({2'b00, pn_q});
  assign err_c  = np_raw[COUNT_BITS+1] || (np_raw == '0);
  assign np_c   = (np_raw > $signed({2'b00, {COUNT_BITS{1'b1}}})) ? '1 :
                  np_raw[COUNT_BITS-1:0];
  assign np1    = np_c - COUNT_BITS'(1);
  assign ndiff  = $signed({1'b0, n_q}) - $signed({1'b0, pm_q});
  assign lpm    = (pm_q == '0) ? '0 : pm_q - COUNT_BITS'(1);
  assign lpn    = (pn_q == '0) ? '0 : pn_q - COUNT_BITS'(1);
  assign ln     = (n_q == '0) ? '0 : n_q - COUNT_BITS'(1);

  assign status_o.done   = done_q;
  assign status_o.err    = err_c;
  assign status_o.np_one = (np_c == COUNT_BITS'(1));

  // operand select
  logic [DATA_W-1:0] src_v [NUM_SRC];
  logic [DATA_W-1:0] op_a, op_b;

  always_comb begin
    for (int i = 0; i < NUM_SRC; i++) begin
      src_v[i] = '0;
    end
    src_v[SRC_N]     = DATA_W'(n_q);
    src_v[SRC_S]     = s_q;
    src_v[SRC_U]     = u_q;
    src_v[SRC_V]     = v_q;
    src_v[SRC_PM]    = DATA_W'(pm_q);
    src_v[SRC_SM]    = sm_q;
    src_v[SRC_UM]    = um_q;
    src_v[SRC_VM]    = DATA_W'(vm_q);
    src_v[SRC_PN]    = DATA_W'(pn_q);
    src_v[SRC_SN]    = sn_q;
    src_v[SRC_UN]    = un_q;
    src_v[SRC_VN]    = DATA_W'(vn_q);
    src_v[SRC_NP]    = DATA_W'(np_c);
    src_v[SRC_NP1]   = DATA_W'(np1);
    src_v[SRC_LPM]   = DATA_W'(lpm);
    src_v[SRC_LPN]   = DATA_W'(lpn);
    src_v[SRC_LN]    = DATA_W'(ln);
    src_v[SRC_N2]    = DATA_W'({n_q, 1'b0});
    src_v[SRC_NDIFF] = {{(DATA_W-COUNT_BITS-1){ndiff[COUNT_BITS]}}, ndiff};
    src_v[SRC_UP]    = up_q;
    src_v[SRC_T0]    = t_q[0];
    src_v[SRC_T1]    = t_q[1];
    src_v[SRC_T2]    = t_q[2];
    src_v[SRC_T3]    = t_q[3];
    src_v[SRC_T4]    = t_q[4];
  end

  assign op_a = src_v[cmd_i.uop.sa];
  assign op_b = src_v[cmd_i.uop.sb];

  // saturating add / subtract
  logic [DATA_W:0]   addsub;
  logic [DATA_W-1:0] addsub_sat;

  always_comb begin
    if (cmd_i.uop.op == OP_SUB) begin
      addsub = {op_a[DATA_W-1], op_a} - {op_b[DATA_W-1], op_b};
    end else begin
      addsub = {op_a[DATA_W-1], op_a} + {op_b[DATA_W-1], op_b};
    end
    if (addsub[DATA_W] != addsub[DATA_W-1]) begin
      addsub_sat = addsub[DATA_W] ? S_MIN : S_MAX;
    end else begin
      addsub_sat = addsub[DATA_W-1:0];
    end
  end

  // multiplier digit and result
  logic [DATA_W+MUL_DIGIT-1:0] pp;
  logic [PROD_W-1:0]           prod_sh;
  logic [DATA_W-1:0]           mul_lim, mul_mag, mul_res;

  assign pp = mag_a_q * mag_b_q[DATA_W-1 -: MUL_DIGIT];

  always_comb begin
    prod_sh = shf_q ? (acc_q >> FRAC_BITS) : acc_q;
    mul_lim = neg_q ? S_MIN : S_MAX;
    mul_mag = ((|prod_sh[PROD_W-1:DATA_W]) || prod_sh[DATA_W-1:0] > mul_lim) ? mul_lim :
              prod_sh[DATA_W-1:0];
    mul_res = neg_q ? (DATA_W'(0) - mul_mag) : mul_mag;
  end

  // restoring divider step
  logic [COUNT_BITS:0] drem_t, drem_n;
  logic                dge;
  logic [DATA_W-1:0]   quo, div_res;

  always_comb begin
    drem_t  = {rem_q, dvd_q[DATA_W-1]};
    dge     = drem_t >= {1'b0, dsr_q};
    drem_n  = dge ? drem_t - {1'b0, dsr_q} : drem_t;
    quo     = {dvd_q[DATA_W-2:0], dge};
    div_res = neg_q ? (DATA_W'(0) - quo) : quo;
  end

  // square root step
  logic [ROOT_W+2:0] srem_t, strial;
  logic              sge;

  always_comb begin
    srem_t = {srem_q[ROOT_W:0], rad_q[RAD_W-1 -: 2]};
    strial = (ROOT_W+3)'({root_q, 2'b01});
    sge    = srem_t >= strial;
  end

  // write-back
  logic              wb_en;
  logic [DATA_W-1:0] wb_val;
  logic              is_addsub;

  assign is_addsub = (cmd_i.uop.op == OP_ADD) || (cmd_i.uop.op == OP_SUB);

  always_comb begin
    wb_en  = 1'b0;
    wb_val = addsub_sat;
    if (unit_q == U_IDLE && cmd_i.start && is_addsub) begin
      wb_en = 1'b1;
    end else if (unit_q == U_MFIN) begin
      wb_en  = 1'b1;
      wb_val = mul_res;
    end else if (unit_q == U_DIV && step_q == '0) begin
      wb_en  = 1'b1;
      wb_val = div_res;
    end
  end

  // control and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= U_IDLE;
      step_q <= '0;
      done_q <= 1'b0;
      n_q    <= '0;
      s_q    <= '0;
      u_q    <= '0;
      v_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (unit_q)
        U_IDLE: begin
          if (cmd_i.start) begin
            case (cmd_i.uop.op)
              OP_ADD, OP_SUB: done_q <= 1'b1;
              OP_MUL, OP_MULF: begin
                unit_q <= U_MUL;
                step_q <= STEP_W'(MUL_STEPS - 1);
              end
              OP_DIV: begin
                unit_q <= U_DIV;
                step_q <= STEP_W'(DATA_W - 1);
              end
              default: done_q <= 1'b1;
            endcase
          end else if (cmd_i.root) begin
            unit_q <= U_SQRT;
            step_q <= STEP_W'(ROOT_W - 1);
          end
        end
        U_MUL: begin
          if (step_q == '0) begin
            unit_q <= U_MFIN;
          end else begin
            step_q <= step_q - STEP_W'(1);
          end
        end
        U_MFIN: begin
          unit_q <= U_IDLE;
          done_q <= 1'b1;
        end
        U_DIV, U_SQRT: begin
          if (step_q == '0) begin
            unit_q <= U_IDLE;
            done_q <= 1'b1;
          end else begin
            step_q <= step_q - STEP_W'(1);
          end
        end
        default: unit_q <= U_IDLE;
      endcase
      if (cmd_i.commit) begin
        n_q <= np_c;
        s_q <= sp_q;
        u_q <= up_q;
        v_q <= status_o.np_one ? DATA_W'(vn_q) : vp_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      pm_q <= old_count_i;
      sm_q <= old_sum_i;
      um_q <= old_mean_i;
      vm_q <= old_variance_i;
      pn_q <= new_count_i;
      sn_q <= new_sum_i;
      un_q <= new_mean_i;
      vn_q <= new_variance_i;
    end
    if (cmd_i.check) begin
      err_q <= err_c;
    end

    if (unit_q == U_IDLE && cmd_i.start) begin
      // a divide takes its sign from the dividend alone
      neg_q   <= (cmd_i.uop.op == OP_DIV) ? op_a[DATA_W-1] :
                 (op_a[DATA_W-1] ^ op_b[DATA_W-1]);
      shf_q   <= (cmd_i.uop.op == OP_MULF);
      mag_a_q <= op_a[DATA_W-1] ? (DATA_W'(0) - op_a) : op_a;
      mag_b_q <= op_b[DATA_W-1] ? (DATA_W'(0) - op_b) : op_b;
      acc_q   <= '0;
      if (cmd_i.uop.op == OP_DIV) begin
        // divisor is a positive count
        dvd_q <= op_a[DATA_W-1] ? (DATA_W'(0) - op_a) : op_a;
        dsr_q <= op_b[COUNT_BITS-1:0];
        rem_q <= '0;
      end
    end

    if (unit_q == U_MUL) begin
      acc_q   <= {acc_q[PROD_W-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}} + PROD_W'(pp);
      mag_b_q <= {mag_b_q[DATA_W-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}};
    end

    if (unit_q == U_DIV) begin
      rem_q <= drem_n[COUNT_BITS-1:0];
      dvd_q <= quo;
    end

    if (unit_q == U_IDLE && cmd_i.root) begin
      rad_q  <= RAD_W'({v_q[VAR_W-1:0], {FRAC_BITS{1'b0}}});
      srem_q <= '0;
      root_q <= '0;
    end else if (unit_q == U_SQRT) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      srem_q <= sge ? srem_t - strial : srem_t;
      root_q <= {root_q[ROOT_W-2:0], sge};
    end

    if (wb_en) begin
      case (cmd_i.uop.dst)
        DST_T0:  t_q[0] <= wb_val;
        DST_T1:  t_q[1] <= wb_val;
        DST_T2:  t_q[2] <= wb_val;
        DST_T3:  t_q[3] <= wb_val;
        DST_T4:  t_q[4] <= wb_val;
        DST_SP:  sp_q   <= wb_val;
        DST_UP:  up_q   <= wb_val;
        // clamp a negative variance to zero
        DST_VP:  vp_q   <= wb_val[DATA_W-1] ? '0 : wb_val;
        default: t_q[0] <= wb_val;
      endcase
    end

    if (cmd_i.publish) begin
      out_cnt_q  <= n_q;
      out_sum_q  <= s_q;
      out_mean_q <= u_q;
      out_var_q  <= v_q[VAR_W-1:0];
      out_std_q  <= VAR_W'(root_q);
      out_err_q  <= err_q;
    end
  end

  assign total_count_o    = out_cnt_q;
  assign total_sum_o      = out_sum_q;
  assign total_mean_o     = out_mean_q;
  assign total_variance_o = out_var_q;
  assign total_std_dev_o  = out_std_q;
  assign empty_error_o    = out_err_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start || cmd_i.root) |-> unit_q == U_IDLE)
    else $error("unit started while busy");

  a_commit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> n_q != '0)
    else $error("committed an empty count");

  a_var_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[DATA_W-1])
    else $error("running variance negative");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held longer than one cycle");

endmodule

@@ sv/pooled_mean_variance_update.sv @@
// Channel  Handshake                 Beat payload
// in       in_valid_i / in_stall_o   old_count/sum/mean/variance, new_count/sum/mean/variance
// out      out_valid_o / out_stall_i total_count/sum/mean/variance/std_dev, empty_error
//
// One beat in, one beat out. A full update runs 13 multiplies (one 8-bit digit
// per cycle), two restoring divides and a square root with a ROOT_W (44) bit
// result. A total count of one skips the variance work; an empty total runs
// only the square root.
// Reset clears the running count, sum, mean and variance to zero.
// in_stall_o is high from the accepted beat until its result is registered; a
// held result does not block the next input beat.
module pooled_mean_variance_update import pmvu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [COUNT_BITS-1:0]    old_count_i,
  input  logic signed [DATA_W-1:0] old_sum_i,
  input  logic signed [DATA_W-1:0] old_mean_i,
  input  logic [VAR_W-1:0]         old_variance_i,
  input  logic [COUNT_BITS-1:0]    new_count_i,
  input  logic signed [DATA_W-1:0] new_sum_i,
  input  logic signed [DATA_W-1:0] new_mean_i,
  input  logic [VAR_W-1:0]         new_variance_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [COUNT_BITS-1:0]    total_count_o,
  output logic signed [DATA_W-1:0] total_sum_o,
  output logic signed [DATA_W-1:0] total_mean_o,
  output logic [VAR_W-1:0]         total_variance_o,
  output logic [VAR_W-1:0]         total_std_dev_o,
  output logic                     empty_error_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  pmvu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  pmvu_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_load_i        (in_accept),
    .old_count_i      (old_count_i),
    .old_sum_i        (old_sum_i),
    .old_mean_i       (old_mean_i),
    .old_variance_i   (old_variance_i),
    .new_count_i      (new_count_i),
    .new_sum_i        (new_sum_i),
    .new_mean_i       (new_mean_i),
    .new_variance_i   (new_variance_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .total_count_o    (total_count_o),
    .total_sum_o      (total_sum_o),
    .total_mean_o     (total_mean_o),
    .total_variance_o (total_variance_o),
    .total_std_dev_o  (total_std_dev_o),
    .empty_error_o    (empty_error_o)
  );

endmodule
